// File: rtl/kio_pkg.sv
// Shared widths, reset values and register indexes of the keyed inner outline block.
// Used by the channel interfaces, the line store and the top level.
`timescale 1ns / 1ps

package kio_pkg;

	// Payload and configuration field widths
	localparam int PIX_W      = 16;
	localparam int OUT_COL_W  = 7;
	localparam int ROW_W      = 12;
	localparam int WIDTH_W    = 8;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Geometry limits and defaults
	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_PIXELS = 64 * 64;
	localparam logic [HEIGHT_W-1:0] ROW_LIMIT = HEIGHT_W'(4096);

	// Register reset values
	localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = WIDTH_W'(64);
	localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = HEIGHT_W'(64);
	localparam logic [PIX_W-1:0]    RST_KEY          = '0;
	localparam logic [PIX_W-1:0]    RST_OUTLINE      = '0;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 4'd0,
		REG_IMAGE_HEIGHT   = 4'd1,
		REG_KEY_COLOUR     = 4'd2,
		REG_OUTLINE_COLOUR = 4'd3
	} cfg_reg_t;

endpackage

// File: rtl/kio_in_if.sv
// Pixel input channel: valid/ready handshake carrying one raster-order pixel.
// Depends on kio_pkg for the pixel width.
`timescale 1ns / 1ps

interface kio_in_if;
	logic                     valid;
	logic                     ready;
	logic [kio_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

// File: rtl/kio_out_if.sv
// Result channel: valid/ready handshake carrying one output pixel and its position.
// Depends on kio_pkg for the field widths.
`timescale 1ns / 1ps

interface kio_out_if;
	logic                         valid;
	logic                         ready;
	logic [kio_pkg::PIX_W-1:0]     pixel_out;
	logic [kio_pkg::OUT_COL_W-1:0] out_col;
	logic [kio_pkg::ROW_W-1:0]     out_row;
	logic                         run_last;

	modport source (output valid, output pixel_out, output out_col, output out_row,
		output run_last, input ready);
	modport sink (input valid, input pixel_out, input out_col, input out_row,
		input run_last, output ready);
endinterface

// File: rtl/kio_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying a register index and data.
// Depends on kio_pkg for the index and data widths.
`timescale 1ns / 1ps

interface kio_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kio_pkg::CFG_IDX_W-1:0]  index;
	logic [kio_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/keyed_inner_outline.sv
// Top level of the keyed inner outline block: configuration, position counting,
// the result stage and the output register. Depends on kio_pkg, the channel
// interfaces and kio_line_mem.
//
// Usage: pixels of an image enter in raster order on the pixels channel; each
// transaction on results carries one output pixel with its column and row, and
// run_last marks the final result caused by one input pixel. A pixel of a
// middle row releases the pixel above it; a pixel of the last row releases the
// pixel above and then itself (two results); pixels of row 0 release nothing
// unless the image has a single row. Oversized or zero-sized images pass through.
// Registers are written on the cfg channel, which is always ready; a write of
// image width or height restarts the image at column 0, row 0.
// Path: each input passes the result stage and then the output register before
// its result is presented on results. Throughput: one pixel per cycle while
// the receiver keeps up, set by the single read-modify-write pass through the
// line store; a last-row pixel holds the result stage until both of its
// results are out, as the output register moves one result per cycle.
// Reset clears the counters and the pipeline and restores the register
// defaults; the line store needs no clearing, as row 0 fills it. When the
// receiver stalls, the output register and the result stage hold and pixels
// stops being ready once both are occupied.
`timescale 1ns / 1ps

module keyed_inner_outline #(
	parameter int MAX_WIDTH  = kio_pkg::DEF_MAX_WIDTH,
	parameter int MAX_PIXELS = kio_pkg::DEF_MAX_PIXELS
) (
	input logic      clk,
	input logic      arst_n,
	kio_in_if.sink   pixels,
	kio_out_if.source results,
	kio_cfg_if.sink  cfg
);
	import kio_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CMP_W  = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
	localparam int PROD_W = WIDTH_W + HEIGHT_W;
	localparam logic [CMP_W-1:0]  WIDTH_CAP = CMP_W'(MAX_WIDTH);
	localparam logic [PROD_W-1:0] PIX_LIMIT = PROD_W'(MAX_PIXELS);
	localparam logic [COL_W-1:0]  LAST_ADDR = COL_W'(MAX_WIDTH - 1);

	// Configuration registers
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [PIX_W-1:0]    key_q;
	logic [PIX_W-1:0]    outline_q;
	logic                cfg_write;
	logic                geom_write;

	// Geometry
	logic [CMP_W-1:0]    width_ext;
	logic [CMP_W-1:0]    w_cap;
	logic [HEIGHT_W-1:0] h_cap;
	logic [PROD_W-1:0]   area;
	logic                pass;

	// Position counters
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [CMP_W-1:0]    col_next;
	logic [HEIGHT_W-1:0] row_next;
	logic                col_wrap;
	logic                row_wrap;
	logic [COL_W-1:0]    right_col;

	// Handshake
	logic accept;
	logic out_free;
	logic s1_emit;
	logic s1_done;

	// Result stage
	logic                s1_valid;
	logic                phase_q;
	logic [PIX_W-1:0]    px_s1;
	logic [COL_W-1:0]    x_s1;
	logic [ROW_W-1:0]    y_s1;
	logic                pass_s1;
	logic                above_s1;
	logic                top_s1;
	logic                lastrow_s1;
	logic                first_col_s1;
	logic                last_col_s1;
	logic                left_above_q;

	// Line store data
	logic [PIX_W-1:0]    here_pix;
	logic [PIX_W-1:0]    right_pix;
	logic                older_op;

	// Result values
	logic                two_results;
	logic                no_result;
	logic                sel_above;
	logic                here_op;
	logic                c_op;
	logic                edge_above;
	logic [PIX_W-1:0]    res_above;
	logic [PIX_W-1:0]    res_self;

	// Output register
	logic                out_valid_q;
	logic [PIX_W-1:0]    pixel_out_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic [ROW_W-1:0]    out_row_q;
	logic                run_last_q;

	// Configuration port: always ready.
	assign cfg.ready  = 1'b1;
	assign cfg_write  = cfg.valid;
	assign geom_write = cfg_write &&
		((cfg.index == REG_IMAGE_WIDTH) || (cfg.index == REG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= RST_IMAGE_WIDTH;
			height_q  <= RST_IMAGE_HEIGHT;
			key_q     <= RST_KEY;
			outline_q <= RST_OUTLINE;
		end else if (cfg_write) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:    width_q   <= cfg.data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:   height_q  <= cfg.data[HEIGHT_W-1:0];
				REG_KEY_COLOUR:     key_q     <= cfg.data[PIX_W-1:0];
				REG_OUTLINE_COLOUR: outline_q <= cfg.data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry and the pass-through decision.
	always_comb begin
		width_ext = CMP_W'(width_q);
		if (width_q == '0) begin
			w_cap = CMP_W'(1);
		end else if (width_ext > WIDTH_CAP) begin
			w_cap = WIDTH_CAP;
		end else begin
			w_cap = width_ext;
		end
		if (height_q == '0) begin
			h_cap = HEIGHT_W'(1);
		end else if (height_q > ROW_LIMIT) begin
			h_cap = ROW_LIMIT;
		end else begin
			h_cap = height_q;
		end
		area = PROD_W'(width_q) * PROD_W'(height_q);
		pass = (width_q == '0) || (width_ext > WIDTH_CAP) || (height_q == '0) ||
			(height_q > ROW_LIMIT) || (area > PIX_LIMIT);
	end

	// Column and row of the next pixel.
	assign accept    = pixels.valid && pixels.ready;
	assign col_next  = CMP_W'(col_q) + CMP_W'(1);
	assign col_wrap  = col_next >= w_cap;
	assign row_next  = HEIGHT_W'(row_q) + HEIGHT_W'(1);
	assign row_wrap  = row_next >= h_cap;
	assign right_col = (col_q == LAST_ADDR) ? col_q : col_next[COL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom_write) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

	// Line store: read at acceptance, opacity written back when the item retires.
	kio_line_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_mem (
		.clk          (clk),
		.rd_en        (accept),
		.rd_col       (col_q),
		.rd_right_col (right_col),
		.pix_we       (accept && !pass),
		.pix_wdata    (pixels.pixel_in),
		.op_we        (s1_done && !pass_s1 && above_s1),
		.op_col       (x_s1),
		.op_wdata     (c_op),
		.here_pix     (here_pix),
		.right_pix    (right_pix),
		.older_op     (older_op)
	);

	// Result stage payload, captured with the memory read.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pixels.pixel_in;
			x_s1         <= col_q;
			y_s1         <= row_q;
			pass_s1      <= pass;
			above_s1     <= row_q != '0;
			top_s1       <= row_q == ROW_W'(1);
			lastrow_s1   <= row_next == h_cap;
			first_col_s1 <= col_q == '0;
			last_col_s1  <= col_wrap;
		end
	end

	// Outline decision for the pixel above and for the current pixel.
	always_comb begin
		here_op    = px_s1 != key_q;
		c_op       = here_pix != key_q;
		edge_above = first_col_s1 || last_col_s1 || top_s1 || !left_above_q ||
			!older_op || !here_op || (right_pix == key_q);
		res_above  = (c_op && edge_above) ? outline_q : here_pix;
		if (pass_s1) begin
			res_self = px_s1;
		end else begin
			res_self = here_op ? outline_q : px_s1;
		end
		two_results = !pass_s1 && above_s1 && lastrow_s1;
		no_result   = !pass_s1 && !above_s1 && !lastrow_s1;
		sel_above   = !pass_s1 && above_s1 && !phase_q;
	end

	// Stage control: a two-result item holds the stage until its second result is emitted.
	assign out_free     = !out_valid_q || results.ready;
	assign s1_emit      = s1_valid && !no_result && out_free;
	assign s1_done      = s1_valid && (no_result || (out_free && !(two_results && !phase_q)));
	assign pixels.ready = !s1_valid || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid     <= 1'b0;
			phase_q      <= 1'b0;
			left_above_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_done) begin
				s1_valid <= 1'b0;
			end
			if (s1_done) begin
				phase_q <= 1'b0;
			end else if (s1_emit && two_results) begin
				phase_q <= 1'b1;
			end
			if (geom_write) begin
				left_above_q <= 1'b0;
			end else if (s1_done && !pass_s1 && above_s1) begin
				left_above_q <= c_op;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_emit) begin
			if (sel_above) begin
				pixel_out_q <= res_above;
				out_row_q   <= y_s1 - ROW_W'(1);
				run_last_q  <= !lastrow_s1;
			end else begin
				pixel_out_q <= res_self;
				out_row_q   <= y_s1;
				run_last_q  <= 1'b1;
			end
			out_col_q <= OUT_COL_W'(x_s1);
		end
	end

	assign results.valid     = out_valid_q;
	assign results.pixel_out = pixel_out_q;
	assign results.out_col   = out_col_q;
	assign results.out_row   = out_row_q;
	assign results.run_last  = run_last_q;

endmodule

// File: rtl/kio_line_mem.sv
// Line store: pixels of the row above and opacity of the row two above.
// Two synchronous memories with registered reads; depends on kio_pkg.
`timescale 1ns / 1ps

module kio_line_mem #(
	parameter int MAX_WIDTH = kio_pkg::DEF_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_right_col,
	input  logic                          pix_we,
	input  logic [kio_pkg::PIX_W-1:0]     pix_wdata,
	input  logic                          op_we,
	input  logic [$clog2(MAX_WIDTH)-1:0]  op_col,
	input  logic                          op_wdata,
	output logic [kio_pkg::PIX_W-1:0]     here_pix,
	output logic [kio_pkg::PIX_W-1:0]     right_pix,
	output logic                          older_op
);
	import kio_pkg::*;

	logic [PIX_W-1:0] pix_mem [MAX_WIDTH];
	logic             op_mem [MAX_WIDTH];
	logic [PIX_W-1:0] here_q;
	logic [PIX_W-1:0] right_q;
	logic             older_q;

	// Pixel row store: the read at the written column returns the old row.
	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[rd_col] <= pix_wdata;
		end
		if (rd_en) begin
			here_q  <= pix_mem[rd_col];
			right_q <= pix_mem[rd_right_col];
		end
	end

	// Opacity store, written back late; a write in the same cycle is forwarded.
	always_ff @(posedge clk) begin
		if (op_we) begin
			op_mem[op_col] <= op_wdata;
		end
		if (rd_en) begin
			if (op_we && (op_col == rd_col)) begin
				older_q <= op_wdata;
			end else begin
				older_q <= op_mem[rd_col];
			end
		end
	end

	assign here_pix  = here_q;
	assign right_pix = right_q;
	assign older_op  = older_q;

endmodule

// File: bench/kio_outline_checker.sv
// Checker for the keyed inner outline block: watches the pixel, result and register channels.
// Keeps its own outline predictor and compares every result transaction in order.
// Depends on kio_pkg and the three channel interfaces.
`timescale 1ns / 1ps

module kio_outline_checker (
	input  logic clk,
	input  logic arst_n,
	kio_in_if    pixels,
	kio_out_if   results,
	kio_cfg_if   cfg,
	output int   fail_count,
	output int   pending_count,
	output int   result_count
);
	import kio_pkg::*;

	localparam int unsigned LINE_LEN = DEF_MAX_WIDTH;

	typedef struct packed {
		logic [PIX_W-1:0]     pix;
		logic [OUT_COL_W-1:0] col;
		logic [ROW_W-1:0]     row;
		logic                 last;
	} outline_px_t;

	// Register copies and the line state of the predictor.
	logic [WIDTH_W-1:0]  img_width;
	logic [HEIGHT_W-1:0] img_height;
	logic [PIX_W-1:0]    key_colour;
	logic [PIX_W-1:0]    outline_colour;
	logic [PIX_W-1:0]    line_above [LINE_LEN];
	logic                opaque_two_up [LINE_LEN];
	logic                opaque_up_left;
	int unsigned         col_pos;
	int unsigned         row_pos;

	outline_px_t awaited_px [$];
	int          mismatches;
	int          compared;

	// Oversized or degenerate geometry sends every pixel straight through.
	function automatic bit bypass_mode();
		int unsigned w;
		int unsigned h;
		w = img_width;
		h = img_height;
		if (w == 0 || w > LINE_LEN)
			return 1'b1;
		if (h == 0 || h > ROW_LIMIT)
			return 1'b1;
		return w * h > DEF_MAX_PIXELS;
	endfunction

	task automatic await_px(input logic [PIX_W-1:0] pix, input int unsigned x,
		input int unsigned y, input logic last);
		awaited_px.push_back('{pix: pix, col: OUT_COL_W'(x), row: ROW_W'(y), last: last});
	endtask

	// Works out the results one accepted pixel releases and advances the position.
	task automatic predict_outline(input logic [PIX_W-1:0] px);
		int unsigned x;
		int unsigned y;
		int unsigned w;
		int unsigned h;
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] shown;
		bit here_op;
		bit above_op;
		bit edge_px;
		bit last_row;
		x = col_pos;
		y = row_pos;
		w = (img_width == 0) ? 1 : img_width;
		if (w > LINE_LEN)
			w = LINE_LEN;
		h = (img_height == 0) ? 1 : img_height;
		if (h > ROW_LIMIT)
			h = ROW_LIMIT;
		if (x >= LINE_LEN)
			x = 0;

		if (bypass_mode()) begin
			await_px(px, x, y, 1'b1);
		end else begin
			here_op = px != key_colour;
			last_row = (y + 1 == h);
			// The pixel above is final once its lower neighbour is known.
			if (y >= 1) begin
				above = line_above[x];
				above_op = above != key_colour;
				shown = above;
				if (above_op) begin
					edge_px = x == 0 || x + 1 >= w || y - 1 == 0 || !opaque_up_left
						|| !opaque_two_up[x] || !here_op;
					if (!edge_px && x + 1 < LINE_LEN && line_above[x + 1] == key_colour)
						edge_px = 1'b1;
					if (edge_px)
						shown = outline_colour;
				end
				await_px(shown, x, y - 1, !last_row);
				opaque_up_left = above_op;
				opaque_two_up[x] = above_op;
			end
			// The last row has no lower neighbour, so it is released at once.
			if (last_row)
				await_px(here_op ? outline_colour : px, x, y, 1'b1);
			line_above[x] = px;
		end

		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h)
				y = 0;
		end
		col_pos = x;
		row_pos = y;
	endtask

	// Geometry writes restart the image; colour writes do not.
	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx) inside
		REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
			if (idx == REG_IMAGE_WIDTH)
				img_width = val[WIDTH_W-1:0];
			else
				img_height = val[HEIGHT_W-1:0];
			col_pos = 0;
			row_pos = 0;
			opaque_up_left = 1'b0;
		end
		REG_KEY_COLOUR: begin
			key_colour = val;
		end
		REG_OUTLINE_COLOUR: begin
			outline_colour = val;
		end
		default: begin
		end
		endcase
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] result check failed: %s", $time, what);
		mismatches++;
	endtask

	// Compares one result transaction with the oldest awaited pixel.
	task automatic check_result();
		outline_px_t want;
		if (awaited_px.size() == 0) begin
			report_mismatch($sformatf("unexpected result %h at col %0d row %0d",
				results.pixel_out, results.out_col, results.out_row));
			return;
		end
		want = awaited_px.pop_front();
		compared++;
		if (results.pixel_out !== want.pix)
			report_mismatch($sformatf("pixel_out %h, expected %h (col %0d row %0d)",
				results.pixel_out, want.pix, want.col, want.row));
		if (results.out_col !== want.col)
			report_mismatch($sformatf("out_col %0d, expected %0d", results.out_col, want.col));
		if (results.out_row !== want.row)
			report_mismatch($sformatf("out_row %0d, expected %0d", results.out_row, want.row));
		if (results.run_last !== want.last)
			report_mismatch($sformatf("run_last %b, expected %b (col %0d row %0d)",
				results.run_last, want.last, want.col, want.row));
	endtask

	// Transactions are taken in channel order within one edge: registers, pixels, results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width = RST_IMAGE_WIDTH;
			img_height = RST_IMAGE_HEIGHT;
			key_colour = RST_KEY;
			outline_colour = RST_OUTLINE;
			foreach (line_above[i]) begin
				line_above[i] = '0;
				opaque_two_up[i] = 1'b0;
			end
			opaque_up_left = 1'b0;
			col_pos = 0;
			row_pos = 0;
			awaited_px.delete();
			mismatches = 0;
			compared = 0;
			fail_count <= 0;
			pending_count <= 0;
			result_count <= 0;
		end else begin
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
				apply_register(cfg.index, cfg.data);
			if (pixels.valid === 1'b1 && pixels.ready === 1'b1)
				predict_outline(pixels.pixel_in);
			if (results.valid === 1'b1 && results.ready === 1'b1)
				check_result();
			fail_count <= mismatches;
			pending_count <= awaited_px.size();
			result_count <= compared;
		end
	end

endmodule

// File: bench/keyed_inner_outline_test.sv
// Testbench top for keyed_inner_outline: clock, reset, pixel and register stimulus.
// Result checking lives in kio_outline_checker; depends on kio_pkg and the channel interfaces.
`timescale 1ns / 1ps

module keyed_inner_outline_test;
	import kio_pkg::*;

	localparam int HALF_PERIOD_NS = 6;
	localparam int TARGET_PIXELS  = 1100;
	localparam int QUIET_TAIL     = 150;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TIMEOUT_NS     = 10_000_000;
	localparam int SPARE_IDX_HI   = (1 << CFG_IDX_W) - 1;

	logic clk;
	logic arst_n;

	kio_in_if  pix_ch ();
	kio_out_if res_ch ();
	kio_cfg_if cfg_ch ();

	int fail_count;
	int pending_count;
	int result_count;

	bit               send_gaps;
	bit               sink_stalls;
	int               pixels_sent;
	int               setups_run;
	logic [PIX_W-1:0] cur_key;

	keyed_inner_outline DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	kio_outline_checker outline_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixels        (pix_ch),
		.results       (res_ch),
		.cfg           (cfg_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.result_count  (result_count)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #HALF_PERIOD_NS clk = ~clk;

	// Result receiver: ready drops in random bursts while stalls are enabled.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	// Register write; always called at a clock edge and returns at a later edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		setups_run++;
	endtask

	// One pixel transaction, possibly preceded by an idle burst. Valid stays high afterward.
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_in <= px;
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
		pixels_sent++;
	endtask

	// Holds the pixel stream until every predicted result has been seen.
	task automatic wait_drain();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_colour();
		case ($urandom_range(0, 3))
		0: return '0;
		1: return '1;
		default: return PIX_W'($urandom);
		endcase
	endfunction

	// Key pixels, near misses of the key, and arbitrary colours.
	function automatic logic [PIX_W-1:0] make_pixel(input int unsigned key_pct);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < key_pct)
			return cur_key;
		if (roll < key_pct + 6)
			return cur_key ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
		return PIX_W'($urandom);
	endfunction

	// One random setup followed by a burst of pixels under it.
	task automatic run_phase(input bit quiet);
		int unsigned w;
		int unsigned h;
		int unsigned burst;
		int unsigned key_pct;
		int          pause_at;
		int          kind;
		bit          new_geometry;
		logic [CFG_DATA_W-1:0] wdata;
		logic [CFG_DATA_W-1:0] hdata;

		kind = $urandom_range(0, 99);
		new_geometry = 1'b1;
		w = 1;
		h = 1;
		if (kind < 72) begin
			// Small images, usually several complete ones in a row.
			w = $urandom_range(1, 10);
			h = $urandom_range(1, 8);
			burst = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
		end else if (kind < 80) begin
			// Largest geometries still inside the pixel budget.
			case ($urandom_range(0, 3))
			0: begin w = DEF_MAX_WIDTH; h = $urandom_range(1, 2); end
			1: begin w = 64; h = 64; end
			2: begin w = 1; h = ROW_LIMIT; end
			default: begin w = $urandom_range(2, 4); h = DEF_MAX_PIXELS / w; end
			endcase
			burst = (h <= 2) ? w * h : $urandom_range(20, 140);
		end else if (kind < 92) begin
			// Geometries that force the pass-through path.
			case ($urandom_range(0, 4))
			0: begin w = 0; h = $urandom_range(1, 64); end
			1: begin w = $urandom_range(DEF_MAX_WIDTH + 1, 255); h = $urandom_range(1, 32); end
			2: begin w = $urandom_range(1, DEF_MAX_WIDTH); h = 0; end
			3: begin w = $urandom_range(1, DEF_MAX_WIDTH); h = $urandom_range(ROW_LIMIT + 1, 8191); end
			default: begin
				w = $urandom_range(65, DEF_MAX_WIDTH);
				h = DEF_MAX_PIXELS / w + $urandom_range(1, 4);
			end
			endcase
			burst = $urandom_range(5, 25);
		end else begin
			// Colours only: the current image carries on where it stopped.
			new_geometry = 1'b0;
			burst = $urandom_range(5, 30);
		end

		send_gaps = quiet ? 1'b0 : ($urandom_range(0, 2) != 0);
		sink_stalls = quiet ? 1'b0 : ($urandom_range(0, 2) != 0);
		case ($urandom_range(0, 2))
		0: key_pct = 10;
		1: key_pct = 35;
		default: key_pct = 60;
		endcase

		if (new_geometry) begin
			wdata = CFG_DATA_W'(w);
			hdata = CFG_DATA_W'(h);
			// Upper bits beyond the register width must be dropped.
			if ($urandom_range(0, 3) == 0) begin
				wdata[CFG_DATA_W-1:WIDTH_W] = (CFG_DATA_W - WIDTH_W)'($urandom);
				hdata[CFG_DATA_W-1:HEIGHT_W] = (CFG_DATA_W - HEIGHT_W)'($urandom);
			end
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_IMAGE_WIDTH, wdata);
				write_reg(REG_IMAGE_HEIGHT, hdata);
			end else begin
				write_reg(REG_IMAGE_HEIGHT, hdata);
				write_reg(REG_IMAGE_WIDTH, wdata);
			end
		end
		if (!new_geometry || $urandom_range(0, 1) == 0) begin
			cur_key = pick_colour();
			write_reg(REG_KEY_COLOUR, cur_key);
		end
		if (!new_geometry || $urandom_range(0, 1) == 0)
			write_reg(REG_OUTLINE_COLOUR, pick_colour());
		if ($urandom_range(0, 9) == 0)
			write_reg(CFG_IDX_W'($urandom_range(REG_OUTLINE_COLOUR + 1, SPARE_IDX_HI)),
				CFG_DATA_W'($urandom));

		pause_at = (burst > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, burst - 1) : -1;
		for (int i = 0; i < burst; i++) begin
			if (i == pause_at)
				wait_drain();
			send_pixel(make_pixel(key_pct));
		end
		wait_drain();
	endtask

	// Main sequence: reset, directed cases, random phases, verdict.
	initial begin
		arst_n <= 1'b0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel_in <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		send_gaps = 1'b0;
		sink_stalls = 1'b0;
		pixels_sent = 0;
		setups_run = 0;
		cur_key = RST_KEY;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A 3x3 image with three keyed corners; the centre has four opaque neighbours.
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		cur_key = 16'h1234;
		write_reg(REG_KEY_COLOUR, cur_key);
		write_reg(REG_OUTLINE_COLOUR, 16'hFFFF);
		send_pixel(cur_key); send_pixel(16'h0A0A); send_pixel(cur_key);
		send_pixel(16'h0A0A); send_pixel(16'h5555); send_pixel(16'h0A0A);
		send_pixel(16'hFFFF); send_pixel(16'h0000); send_pixel(cur_key);
		wait_drain();

		// Single row: each pixel releases only itself.
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		send_pixel(cur_key); send_pixel(16'h0000); send_pixel(16'hFFFF);
		wait_drain();

		// Zero width, then an image over the pixel budget: both pass through.
		write_reg(REG_IMAGE_WIDTH, 16'd0);
		send_pixel(16'hFFFF); send_pixel(cur_key);
		wait_drain();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(DEF_MAX_WIDTH));
		write_reg(REG_IMAGE_HEIGHT, 16'd33);
		send_pixel(16'h8001); send_pixel(cur_key);
		wait_drain();

		// A write to an unused index changes nothing; then a 1x1 image.
		write_reg(CFG_IDX_W'(SPARE_IDX_HI), 16'hFFFF);
		write_reg(REG_IMAGE_WIDTH, 16'd1);
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		send_pixel(cur_key); send_pixel(16'h7FFE);
		wait_drain();

		// Colour writes halfway through a 2x2 image keep the position.
		write_reg(REG_IMAGE_WIDTH, 16'd2);
		write_reg(REG_IMAGE_HEIGHT, 16'd2);
		send_pixel(16'hFFFF); send_pixel(16'h4321);
		wait_drain();
		cur_key = 16'hFFFF;
		write_reg(REG_KEY_COLOUR, cur_key);
		write_reg(REG_OUTLINE_COLOUR, 16'h0000);
		send_pixel(16'h4321); send_pixel(cur_key);
		wait_drain();

		// Random phases; the tail runs with no idling on either side.
		while (pixels_sent < TARGET_PIXELS)
			run_phase(pixels_sent >= TARGET_PIXELS - QUIET_TAIL);
		sink_stalls = 1'b0;
		wait_drain();

		$display("Sent %0d pixels across %0d register writes; %0d results compared.",
			pixels_sent, setups_run, result_count);
		$display("Covered pass-through, single-row, full-width and tall images under idle bursts.");
		if (fail_count == 0 && pending_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule
